// ----- sv/tws_pkg.sv -----
`timescale 1ns / 1ps
// tws_pkg: shared constants and operation codes for the trie word store
// no dependencies; imported by every module of the block

package tws_pkg;

  // default pool geometry
  localparam int NODE_COUNT_DEF    = 256;
  localparam int ALPHABET_SIZE_DEF = 26;

  // fixed field widths of the command port
  localparam int FUNC_W   = 2;
  localparam int LETTER_W = 5;

  // operation codes; the fourth code acts as exact search
  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT       = 2'd0,
    OP_SEARCH       = 2'd1,
    OP_PREFIX       = 2'd2,
    OP_SEARCH_ALIAS = 2'd3
  } op_e;

endpackage

// ----- sv/tws_ram.sv -----
`timescale 1ns / 1ps
// tws_ram: simple dual-port synchronous memory, one write and one read port
// read data registered; uses tws_pkg defaults

module tws_ram
  import tws_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = NODE_COUNT_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/tws_clear.sv -----
`timescale 1ns / 1ps
// tws_clear: post-reset sweep counter that walks every memory address once
// uses tws_pkg defaults

module tws_clear
  import tws_pkg::*;
#(
  parameter int DEPTH = NODE_COUNT_DEF * ALPHABET_SIZE_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          active_o,
  output logic [AW-1:0] addr_o
);

  logic          active_q, active_d;
  logic [AW-1:0] cnt_q, cnt_d;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    if (active_q) begin
      if (cnt_q == AW'(DEPTH - 1)) begin
        active_d = 1'b0;
      end else begin
        cnt_d = cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b1;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  assign active_o = active_q;
  assign addr_o   = cnt_q;

endmodule

// ----- sv/trie_word_store_core.sv -----
`timescale 1ns / 1ps
// trie_word_store_core: top level of the trie word store (walk control + memories)
// depends on tws_pkg, tws_ram, tws_clear

// A trie of lower-case words held as a pool of NODE_COUNT nodes. Each word
// is sent one letter per command word (start_i while busy_o is low) with its
// operation: insert, exact search or prefix test. The word that ends a word
// (last_letter_i or empty_word_i) gives exactly one result: done_o is high
// for one cycle with found_o and pool_full_o; the receiver cannot stall it.
// After reset the block sweeps the link memory (and the mark memory) clear,
// one entry a cycle over NODE_COUNT*ALPHABET_SIZE entries (6656 at the
// defaults), with busy_o high. Each letter is then taken in ST_IDLE, which
// reads the child link memory, and handled in ST_LINK, which follows the link
// or allocates a node and writes the link back, which the next letter needs.
// A word-ending exact search that reaches a node also passes ST_MARK, which
// takes the end-of-word mark read in ST_LINK. The result strobe comes in the
// cycle after the last of those states, while the next word may already be taken.

module trie_word_store_core
  import tws_pkg::*;
#(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [LETTER_W-1:0] letter_i,
  input  logic                last_letter_i,
  input  logic                empty_word_i,
  output logic                done_o,
  output logic                found_o,
  output logic                pool_full_o
);

  // geometry
  localparam int LINK_DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int FREE_W     = $clog2(NODE_COUNT + 1);
  localparam int LA_W       = $clog2(LINK_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINK,
    ST_MARK
  } state_e;

  // walk state and latched command
  state_e            state_q, state_d;
  logic [NODE_W-1:0] cur_q, cur_d;
  logic [FREE_W-1:0] free_q, free_d;
  logic              miss_q, miss_d;
  logic              ovf_q, ovf_d;
  op_e               op_q, op_d;
  logic              end_q, end_d;
  logic              empty_q, empty_d;
  logic              cons_q, cons_d;
  logic              bad_q, bad_d;
  logic [LA_W-1:0]   slot_q, slot_d;

  // result registers
  logic              done_q, done_d;
  logic              found_q, found_d;
  logic              full_q, full_d;

  // walk values after this letter
  logic [NODE_W-1:0] cur_n;
  logic              miss_n, ovf_n;

  // memory-side signals
  logic              clr_active;
  logic [LA_W-1:0]   clr_addr;
  logic              link_re, link_we;
  logic [NODE_W-1:0] link_rdata;
  logic              mark_re, mark_we;
  logic [NODE_W-1:0] mark_raddr, mark_waddr;
  logic              mark_rdata;
  logic              skip;
  logic              letter_ok;
  logic              pool_full;
  logic [LA_W-1:0]   slot_calc;
  logic              mark_clr_en;

  assign letter_ok   = (32'(letter_i) < 32'(ALPHABET_SIZE));
  assign pool_full   = (free_q == FREE_W'(NODE_COUNT));
  // node base times alphabet plus letter
  assign slot_calc   = LA_W'(cur_q) * LA_W'(ALPHABET_SIZE) + LA_W'(letter_i);
  assign mark_clr_en = clr_active && ({1'b0, clr_addr} < (LA_W + 1)'(NODE_COUNT));

  // ------------------------------------------------------------------
  // walk control
  // ------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    free_d     = free_q;
    miss_d     = miss_q;
    ovf_d      = ovf_q;
    op_d       = op_q;
    end_d      = end_q;
    empty_d    = empty_q;
    cons_d     = cons_q;
    bad_d      = bad_q;
    slot_d     = slot_q;
    done_d     = 1'b0;
    found_d    = found_q;
    full_d     = full_q;
    link_re    = 1'b0;
    link_we    = 1'b0;
    mark_re    = 1'b0;
    mark_we    = 1'b0;
    mark_raddr = cur_q;
    mark_waddr = cur_q;
    cur_n      = cur_q;
    miss_n     = miss_q;
    ovf_n      = ovf_q;
    skip       = empty_word_i || miss_q || ovf_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i && !clr_active) begin
          op_d    = (op_e'(func_i) == OP_SEARCH_ALIAS) ? OP_SEARCH : op_e'(func_i);
          end_d   = last_letter_i || empty_word_i;
          empty_d = empty_word_i;
          // a missed or overflowed word skips its remaining letters
          bad_d   = !skip && !letter_ok;
          cons_d  = !skip && letter_ok;
          slot_d  = slot_calc;
          link_re = !skip && letter_ok;
          state_d = ST_LINK;
        end
      end

      ST_LINK: begin
        if (bad_q) begin
          miss_n = 1'b1;
        end
        if (cons_q) begin
          if (link_rdata != '0) begin
            // existing child
            cur_n = link_rdata;
          end else if (op_q != OP_INSERT) begin
            miss_n = 1'b1;
          end else if (pool_full) begin
            ovf_n = 1'b1;
          end else begin
            // allocate next free node and link it in
            link_we = 1'b1;
            cur_n   = free_q[NODE_W-1:0];
            free_d  = free_q + FREE_W'(1);
          end
        end
        state_d = ST_IDLE;
        if (end_q) begin
          // word ends: report and restart the walk at the root
          cur_d   = '0;
          miss_d  = 1'b0;
          ovf_d   = 1'b0;
          found_d = 1'b0;
          full_d  = 1'b0;
          case (op_q)
            OP_INSERT: begin
              mark_we    = !empty_q && !miss_n && !ovf_n;
              mark_waddr = cur_n;
              full_d     = ovf_n;
              done_d     = 1'b1;
            end
            OP_PREFIX: begin
              found_d = !miss_n;
              done_d  = 1'b1;
            end
            default: begin
              if (miss_n) begin
                done_d = 1'b1;
              end else begin
                // exact search needs the end mark of the reached node
                mark_re    = 1'b1;
                mark_raddr = cur_n;
                state_d    = ST_MARK;
              end
            end
          endcase
        end else begin
          cur_d  = cur_n;
          miss_d = miss_n;
          ovf_d  = ovf_n;
        end
      end

      ST_MARK: begin
        found_d = mark_rdata;
        full_d  = 1'b0;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= '0;
      free_q  <= FREE_W'(1);
      miss_q  <= 1'b0;
      ovf_q   <= 1'b0;
      op_q    <= OP_INSERT;
      end_q   <= 1'b0;
      empty_q <= 1'b0;
      cons_q  <= 1'b0;
      bad_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      free_q  <= free_d;
      miss_q  <= miss_d;
      ovf_q   <= ovf_d;
      op_q    <= op_d;
      end_q   <= end_d;
      empty_q <= empty_d;
      cons_q  <= cons_d;
      bad_q   <= bad_d;
      done_q  <= done_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    slot_q  <= slot_d;
    found_q <= found_d;
    full_q  <= full_d;
  end

  // ------------------------------------------------------------------
  // memories and clearing sweep
  // ------------------------------------------------------------------
  tws_clear #(
    .DEPTH (LINK_DEPTH)
  ) u_clear (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .active_o (clr_active),
    .addr_o   (clr_addr)
  );

  // child links, one entry per node and letter
  tws_ram #(
    .WIDTH (NODE_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (clr_active || link_we),
    .waddr_i (clr_active ? clr_addr : slot_q),
    .wdata_i (clr_active ? '0 : free_q[NODE_W-1:0]),
    .re_i    (link_re),
    .raddr_i (slot_d),
    .rdata_o (link_rdata)
  );

  // end-of-word marks, one per node
  tws_ram #(
    .WIDTH (1),
    .DEPTH (NODE_COUNT)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_clr_en || mark_we),
    .waddr_i (clr_active ? clr_addr[NODE_W-1:0] : mark_waddr),
    .wdata_i (!clr_active),
    .re_i    (mark_re),
    .raddr_i (mark_raddr),
    .rdata_o (mark_rdata)
  );

  // ------------------------------------------------------------------
  // outputs
  // ------------------------------------------------------------------
  assign busy_o      = clr_active || (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign found_o     = found_q;
  assign pool_full_o = full_q;

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  a_no_result_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active |-> !done_q)
    else $error("result strobe during clearing sweep");

  a_free_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= FREE_W'(NODE_COUNT))
    else $error("free node counter beyond pool size");

  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for two cycles");

  a_accept_to_link : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == ST_LINK))
    else $error("accepted word did not start a link lookup");

endmodule

// ----- dv/tws_tb_pkg.sv -----
`timescale 1ns / 1ps
// tws_tb_pkg: command word type and shadow trie scoreboard for the trie word store bench
// depends on tws_pkg for the operation codes, field widths and pool geometry

package tws_tb_pkg;
  import tws_pkg::*;

  localparam int NODES = NODE_COUNT_DEF;
  localparam int ALPHA = ALPHABET_SIZE_DEF;

  // one command word as it sits on the ports
  typedef struct packed {
    op_e                 func;
    logic [LETTER_W-1:0] letter;
    logic                last;
    logic                empty;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic full;
  } answer_t;

  class trie_shadow;
    logic [7:0]  links [NODES*ALPHA];
    logic        marks [NODES];
    int unsigned free_node;
    int unsigned node;
    bit          missed;
    bit          overflow;
    answer_t     pending_answers[$];
    int unsigned failures;

    function new();
      foreach (links[i]) links[i] = '0;
      foreach (marks[i]) marks[i] = 1'b0;
      free_node = 1;
      failures  = 0;
      walk_home();
    endfunction

    function void walk_home();
      node     = 0;
      missed   = 1'b0;
      overflow = 1'b0;
    endfunction

    // follow or grow one link of the walk
    function void step_letter(op_e op, int unsigned ch);
      int unsigned slot;
      if (missed || overflow) return;
      if (ch >= ALPHA || node >= NODES) begin
        missed = 1'b1;
        return;
      end
      slot = node * ALPHA + ch;
      if (links[slot] != 0) begin
        node = 32'(links[slot]);
        return;
      end
      if (op != OP_INSERT) begin
        missed = 1'b1;
        return;
      end
      if (free_node >= NODES) begin
        overflow = 1'b1;
        return;
      end
      links[slot] = free_node[7:0];
      node        = free_node;
      free_node++;
    endfunction

    // accepted command word: advance the walk, queue an answer on a word end
    function void take_item(cmd_t c);
      op_e     op;
      answer_t a;
      op = (c.func == OP_SEARCH_ALIAS) ? OP_SEARCH : c.func;
      a  = '0;
      if (!c.empty) step_letter(op, 32'(c.letter));
      if (!(c.last || c.empty)) return;
      case (op)
        OP_INSERT: begin
          if (!c.empty && !missed && !overflow && node < NODES) marks[node] = 1'b1;
          a.full = overflow;
        end
        OP_SEARCH: begin
          if (!missed && node < NODES) a.found = marks[node];
        end
        default: begin
          a.found = !missed;
        end
      endcase
      pending_answers.push_back(a);
      walk_home();
    endfunction

    function void complain(string why, answer_t want, answer_t got);
      failures++;
      if (failures <= 10)
        $display("%0t: %s: expected found=%0b full=%0b, got found=%0b full=%0b",
                 $realtime, why, want.found, want.full, got.found, got.full);
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (pending_answers.size() == 0) begin
        complain("unexpected result", 'x, got);
        return;
      end
      want = pending_answers.pop_front();
      if (got.found !== want.found || got.full !== want.full)
        complain("result mismatch", want, got);
    endfunction

    // anything still queued at the end never arrived
    function void close_out();
      while (pending_answers.size() != 0)
        complain("missing result", pending_answers.pop_front(), 'x);
    endfunction
  endclass

endpackage

// ----- dv/tb_trie_word_store_core.sv -----
`timescale 1ns / 1ps
// tb_trie_word_store_core: self-checking bench for the trie word store top level
// depends on tws_pkg, tws_tb_pkg and trie_word_store_core

module tb_trie_word_store_core;
  import tws_pkg::*;
  import tws_tb_pkg::*;

  // run length and watchdog
  localparam int ITEM_GOAL   = 1625;
  localparam int CYCLE_LIMIT = 400000;

  // a word of up to seven letters, as it is spelled onto the command port
  typedef struct packed {
    logic [2:0]                len;
    logic [6:0][LETTER_W-1:0]  ch;
  } word_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                start_i       = 1'b0;
  logic                busy_o;
  logic [FUNC_W-1:0]   func_i        = '0;
  logic [LETTER_W-1:0] letter_i      = '0;
  logic                last_letter_i = 1'b0;
  logic                empty_word_i  = 1'b0;
  logic                done_o;
  logic                found_o;
  logic                pool_full_o;

  trie_shadow  shadow = new();
  int unsigned sent   = 0;
  int unsigned cycles = 0;
  word_t       history[$];

  trie_word_store_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .func_i        (func_i),
    .letter_i      (letter_i),
    .last_letter_i (last_letter_i),
    .empty_word_i  (empty_word_i),
    .done_o        (done_o),
    .found_o       (found_o),
    .pool_full_o   (pool_full_o)
  );

  always #10 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // port monitor: results first, then the word taken at this edge; both sample
  // pre-edge values so the order against the block's own updates does not matter
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) shadow.check_answer(answer_t'({found_o, pool_full_o}));
      if (start_i && !busy_o)
        shadow.take_item(cmd_t'({func_i, letter_i, last_letter_i, empty_word_i}));
    end
  end

  // put one command word on the port and hold it until the block takes it;
  // returns at the accepting edge so the next word can follow back to back
  task automatic send_cmd(cmd_t c);
    bit quiet;
    quiet = (sent >= 700 && sent < 1000);  // long stretch without sender gaps
    while (!quiet && $urandom_range(99) < 38) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    func_i        <= c.func;
    letter_i      <= c.letter;
    last_letter_i <= c.last;
    empty_word_i  <= c.empty;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent++;
  endtask

  // spell a word letter by letter; an empty-word item closes it when asked,
  // or stands alone for a zero-length word
  task automatic send_word(op_e op, word_t w, bit empty_end, bit mix);
    cmd_t c;
    for (int i = 0; i < w.len; i++) begin
      // occasionally a letter carries a different operation
      c.func   = (mix && $urandom_range(99) < 5) ? op_e'($urandom_range(3)) : op;
      c.letter = w.ch[i];
      c.last   = (i == w.len - 1) && !empty_end;
      c.empty  = 1'b0;
      send_cmd(c);
    end
    if (empty_end || w.len == 0) begin
      c.func   = op;
      c.letter = LETTER_W'($urandom_range(31));  // ignored by the block, any value
      c.last   = 1'($urandom_range(1));
      c.empty  = 1'b1;
      send_cmd(c);
    end
  endtask

  function automatic word_t spell(string s);
    word_t w;
    w     = '0;
    w.len = 3'(s.len());
    for (int i = 0; i < s.len(); i++) w.ch[i] = LETTER_W'(s[i] - 8'h61);  // ascii a
    return w;
  endfunction

  // random word: often a four-letter alphabet so paths are shared,
  // otherwise the full alphabet for width, and now and then a letter beyond z
  function automatic word_t fresh_word();
    word_t w;
    int    r;
    w     = '0;
    w.len = 3'($urandom_range(1, 6));
    for (int i = 0; i < w.len; i++) begin
      r = $urandom_range(99);
      if (r < 45)      w.ch[i] = LETTER_W'($urandom_range(3));
      else if (r < 96) w.ch[i] = LETTER_W'($urandom_range(ALPHA - 1));
      else             w.ch[i] = LETTER_W'($urandom_range(31, ALPHA));
    end
    return w;
  endfunction

  // a word inserted earlier, sometimes cut short or with one letter changed
  function automatic word_t recall_word();
    word_t w;
    w = history[$urandom_range(history.size() - 1)];
    if ($urandom_range(99) < 40) w.len = 3'($urandom_range(1, w.len));
    if ($urandom_range(99) < 10)
      w.ch[$urandom_range(w.len - 1)] = LETTER_W'($urandom_range(ALPHA - 1));
    return w;
  endfunction

  initial begin
    word_t w;
    op_e   op;
    int    r;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty words at the root
    send_word(OP_PREFIX, '0, 1'b1, 1'b0);
    send_word(OP_SEARCH, '0, 1'b1, 1'b0);
    send_word(OP_INSERT, '0, 1'b1, 1'b0);
    // top letter, then a word and its prefixes
    send_word(OP_INSERT, spell("z"), 1'b0, 1'b0);
    send_word(OP_SEARCH, spell("z"), 1'b0, 1'b0);
    send_word(OP_INSERT, spell("abc"), 1'b0, 1'b0);
    send_word(OP_SEARCH, spell("ab"), 1'b0, 1'b0);
    send_word(OP_PREFIX, spell("ab"), 1'b0, 1'b0);
    send_word(OP_SEARCH_ALIAS, spell("z"), 1'b0, 1'b0);
    send_word(OP_PREFIX, spell("abd"), 1'b0, 1'b0);
    // letters past z miss for every operation
    w = '0; w.len = 3'd1; w.ch[0] = 5'd31;
    send_word(OP_SEARCH, w, 1'b0, 1'b0);
    w.ch[0] = LETTER_W'(ALPHA);
    send_word(OP_PREFIX, w, 1'b0, 1'b0);
    w = spell("a"); w.len = 3'd2; w.ch[1] = 5'd30;
    send_word(OP_INSERT, w, 1'b0, 1'b0);
    send_word(OP_SEARCH, spell("a"), 1'b0, 1'b0);
    // an insert closed by an empty-word item marks nothing
    send_word(OP_INSERT, spell("ab"), 1'b1, 1'b0);
    send_word(OP_SEARCH, spell("ab"), 1'b1, 1'b0);
    send_word(OP_PREFIX, spell("abc"), 1'b1, 1'b0);
    // mixed operations: the ending word decides the answer
    send_cmd('{func: OP_SEARCH, letter: 5'd0, last: 1'b0, empty: 1'b0});
    send_cmd('{func: OP_INSERT, letter: 5'd16, last: 1'b1, empty: 1'b0});
    send_word(OP_SEARCH, spell("aq"), 1'b0, 1'b0);

    // random words; lookups mostly replay inserted words so walks go deep,
    // and inserts keep going until the pool runs out of nodes
    while (sent < ITEM_GOAL) begin
      r  = $urandom_range(99);
      op = (r < 40) ? OP_INSERT : (r < 70) ? OP_SEARCH :
           (r < 95) ? OP_PREFIX : OP_SEARCH_ALIAS;
      if ($urandom_range(99) < 5)
        w = '0;
      else if (op != OP_INSERT && history.size() != 0 && $urandom_range(99) < 60)
        w = recall_word();
      else
        w = fresh_word();
      send_word(op, w, $urandom_range(99) < 6, 1'b1);
      if (op == OP_INSERT && w.len != 0) begin
        history.push_back(w);
        if (history.size() > 48) void'(history.pop_front());
      end
    end
    start_i <= 1'b0;

    // drain, then keep clocking so a stray strobe would still be caught
    while (shadow.pending_answers.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    shadow.close_out();
    if (shadow.failures == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
